// ===== rtl/pevi_pkg.sv =====
// Shared types and constants for the primitive edge vertex index block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package pevi_pkg;

  localparam int IDX_W   = 31;  // edge index and vertex count width
  localparam int OUT_W   = 32;  // result field width
  localparam int MODE_W  = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int DIV_W   = 32;  // dividend width of the loop remainder

  // ceil(2^33 / 3): (i * RECIP3) >> 33 == i / 3 for any 32-bit i
  localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int          RECIP3_SHIFT = 33;

  typedef enum logic [MODE_W-1:0] {
    MODE_POINTS     = 4'd0,
    MODE_LINES      = 4'd1,
    MODE_LINE_STRIP = 4'd2,
    MODE_LINE_LOOP  = 4'd3,
    MODE_POLYGON    = 4'd4,
    MODE_TRIANGLES  = 4'd5,
    MODE_TRI_STRIP  = 4'd6,
    MODE_TRI_FAN    = 4'd7,
    MODE_QUADS      = 4'd8,
    MODE_QUAD_STRIP = 4'd9
  } draw_mode_t;

  typedef enum logic {
    REG_DRAW_MODE    = 1'b0,
    REG_VERTEX_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] draw_mode;
    logic [IDX_W-1:0]  vertex_count;
  } cfg_t;

  // endpoints from the fixed-pattern modes plus the loop dividend (i + 1)
  typedef struct packed {
    logic [OUT_W-1:0] a;
    logic [OUT_W-1:0] b;
    logic [DIV_W-1:0] d;
  } pl_t;

endpackage

`default_nettype wire

// ===== rtl/pevi_if.sv =====
// Handshake channels: edge index in, vertex pair out.
// Depends on pevi_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pevi_in_if import pevi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] edge_index;

  modport source (output valid, output edge_index, input ready);
  modport sink   (input valid, input edge_index, output ready);
endinterface

interface pevi_out_if import pevi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] vertex_a;
  logic signed [OUT_W-1:0] vertex_b;

  modport source (output valid, output vertex_a, output vertex_b, input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/pevi_cfg.sv =====
// APB-style register file holding draw mode and vertex count.
// Depends on pevi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pevi_cfg import pevi_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t sel;
  logic     wr;

  // registers sit at 4-byte strides; only the word select bit is decoded
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (sel)
        REG_DRAW_MODE:    cfg_nxt.draw_mode    = pwdata[MODE_W-1:0];
        REG_VERTEX_COUNT: cfg_nxt.vertex_count = pwdata[IDX_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_DRAW_MODE:    prdata = PDATA_W'(cfg_r.draw_mode);
      REG_VERTEX_COUNT: prdata = PDATA_W'(cfg_r.vertex_count);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/pevi_geom.sv =====
// Two-stage front end: divide-by-three by reciprocal, then the fixed-pattern
// endpoint formulas for every mode. Depends on pevi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pevi_geom import pevi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [IDX_W-1:0] in_idx,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pl_t                   out_pl
);

  // stage A: index and quotient by three
  logic             va_r;
  logic [IDX_W-1:0] ia_r;
  logic [IDX_W-1:0] q3_r;
  logic             rdy_a;
  logic [63:0]      prod;

  // stage B: endpoints
  logic             vb_r;
  pl_t              plb_r;
  pl_t              plb_nxt;
  logic             rdy_b;

  logic [OUT_W-1:0] i32;
  logic [OUT_W-1:0] t3;
  logic [1:0]       m3;
  logic [IDX_W-1:0] f3;
  logic [IDX_W-1:0] f2;
  logic [OUT_W-1:0] f2w;
  logic [OUT_W-1:0] f3x2;
  logic             o;
  logic             p;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;
  assign prod     = 64'(in_idx) * 64'(RECIP3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      ia_r <= in_idx;
      q3_r <= prod[RECIP3_SHIFT +: IDX_W];
    end
  end

  always_comb begin
    i32  = OUT_W'(ia_r);
    t3   = {q3_r, 1'b0} + OUT_W'(q3_r);
    m3   = 2'(i32 - t3);
    f3   = (m3 == 2'd0) ? q3_r - 1'b1 : q3_r;   // (i - 1) / 3, i > 0
    f3x2 = {f3, 1'b0};
    f2   = (ia_r - 1'b1) >> 1;                   // (i - 1) / 2, i > 0
    f2w  = OUT_W'(f2);
    o    = ia_r[0];
    p    = f2[0];

    plb_nxt.d = i32 + 1'b1;
    plb_nxt.a = i32;
    plb_nxt.b = i32;
    case (cfg.draw_mode)
      MODE_POINTS: begin
        plb_nxt.a = i32;
        plb_nxt.b = i32;
      end
      MODE_LINES: begin
        plb_nxt.a = {ia_r, 1'b0};
        plb_nxt.b = {ia_r, 1'b1};
      end
      MODE_LINE_STRIP: begin
        plb_nxt.b = i32 + 1'b1;
      end
      MODE_LINE_LOOP, MODE_POLYGON: begin
        plb_nxt.b = '0;   // replaced by the remainder at the output stage
      end
      MODE_TRIANGLES: begin
        plb_nxt.b = t3 + ((m3 == 2'd2) ? OUT_W'(0) : OUT_W'(m3 + 2'd1));
      end
      MODE_QUADS: begin
        plb_nxt.b = {1'b0, ia_r[IDX_W-1:2], 2'(ia_r[1:0] + 2'd1)};
      end
      MODE_TRI_STRIP, MODE_TRI_FAN, MODE_QUAD_STRIP: begin
        if (ia_r == '0) begin
          plb_nxt.a = OUT_W'(0);
          plb_nxt.b = OUT_W'(1);
        end else if (cfg.draw_mode == MODE_TRI_STRIP) begin
          plb_nxt.a = f2w + (o ? OUT_W'(!p) : OUT_W'(2));
          plb_nxt.b = f2w + (o ? OUT_W'(2) : OUT_W'(p));
        end else if (cfg.draw_mode == MODE_TRI_FAN) begin
          plb_nxt.a = f2w + (o ? OUT_W'(1) : OUT_W'(2));
          plb_nxt.b = o ? f2w + OUT_W'(2) : OUT_W'(0);
        end else begin
          // (i + 2) mod 3 folded in: m 0 -> 2, 1 -> 0, 2 -> 1
          plb_nxt.a = f3x2 + OUT_W'(m3) +
                      ((m3 == 2'd0) ? OUT_W'(2) : OUT_W'(m3 - 2'd1));
          plb_nxt.b = f3x2 + ((m3 == 2'd0) ? OUT_W'(0) : OUT_W'(3'd4 - 3'(m3)));
        end
      end
      default: begin
        plb_nxt.a = '0;
        plb_nxt.b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      plb_r <= plb_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_pl    = plb_r;

endmodule

`default_nettype wire

// ===== rtl/pevi_rem.sv =====
// Pipelined restoring remainder (i + 1) mod n, one dividend bit per stage,
// carrying the front-end endpoints alongside. Depends on pevi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pevi_rem import pevi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire pl_t              in_pl,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pl_t                   out_pl,
  output logic [IDX_W-1:0]      out_rem
);

  logic [DIV_W-1:0] v_r;
  logic [DIV_W:0]   rdy;
  logic [IDX_W-1:0] r_r  [DIV_W];
  pl_t              pl_r [DIV_W];

  assign rdy[DIV_W] = out_ready;
  assign in_ready   = rdy[0];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic             v_prev;
    pl_t              pl_prev;
    logic [IDX_W-1:0] r_prev;
    logic [IDX_W:0]   rs;
    logic [IDX_W:0]   rsub;
    logic [IDX_W-1:0] r_nxt;

    if (k == 0) begin : g_first
      assign v_prev  = in_valid;
      assign pl_prev = in_pl;
      assign r_prev  = '0;
    end else begin : g_next
      assign v_prev  = v_r[k-1];
      assign pl_prev = pl_r[k-1];
      assign r_prev  = r_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_comb begin
      rs    = {r_prev, pl_prev.d[DIV_W-1-k]};
      rsub  = rs - {1'b0, cfg.vertex_count};
      // for n == 0 the result is garbage and ignored downstream
      r_nxt = (rs >= {1'b0, cfg.vertex_count}) ? rsub[IDX_W-1:0] : rs[IDX_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        pl_r[k] <= pl_prev;
        r_r[k]  <= r_nxt;
      end
    end
  end

  assign out_valid = v_r[DIV_W-1];
  assign out_pl    = pl_r[DIV_W-1];
  assign out_rem   = r_r[DIV_W-1];

`ifndef SYNTHESIS
  a_rem_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[DIV_W-1] && cfg.vertex_count != '0 |-> r_r[DIV_W-1] < cfg.vertex_count)
    else $error("loop remainder not below vertex count");
`endif

endmodule

`default_nettype wire

// ===== rtl/primitive_edge_vertex_index_core.sv =====
// Pipeline: 2 front-end stages, 32 remainder stages and 1 output register lie between
// an accepted beat and its result; one beat per cycle sustained without back-pressure.
// Latency is set by the per-bit remainder pipeline, which every beat passes through.
// Each stage holds its beat under back-pressure while earlier bubbles close up.
// Synchronous active-low reset clears valid bits and sets both registers to 0.
// Depends on pevi_pkg, pevi_if, pevi_cfg, pevi_geom and pevi_rem.
`timescale 1ns / 1ps
`default_nettype none

module primitive_edge_vertex_index_core import pevi_pkg::*; #(
  parameter int INDEX_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  pevi_in_if.sink                 in_ch,
  pevi_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam logic [OUT_W-1:0] IDX_MASK = OUT_W'((64'd1 << INDEX_BITS) - 64'd1);

  cfg_t             cfg;
  logic             g_valid;
  logic             g_ready;
  pl_t              g_pl;
  logic             r_valid;
  logic             r_ready;
  pl_t              r_pl;
  logic [IDX_W-1:0] r_rem;

  logic                  out_v_r;
  logic                  unk_r;
  logic                  unk_nxt;
  logic [INDEX_BITS-1:0] va_r;
  logic [INDEX_BITS-1:0] vb_r;
  logic [OUT_W-1:0]      b_sel;
  logic                  out_rdy;

  pevi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pevi_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_idx    (in_ch.edge_index),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .out_pl    (g_pl)
  );

  pevi_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .in_pl     (g_pl),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .out_pl    (r_pl),
    .out_rem   (r_rem)
  );

  assign out_rdy = !out_v_r || out_ch.ready;
  assign r_ready = out_rdy;

  always_comb begin
    b_sel   = r_pl.b;
    unk_nxt = 1'b0;
    case (cfg.draw_mode)
      MODE_LINE_LOOP, MODE_POLYGON: begin
        b_sel = (cfg.vertex_count == '0) ? '0 : OUT_W'(r_rem);
      end
      MODE_POINTS, MODE_LINES, MODE_LINE_STRIP, MODE_TRIANGLES,
      MODE_TRI_STRIP, MODE_TRI_FAN, MODE_QUADS, MODE_QUAD_STRIP: begin
        b_sel = r_pl.b;
      end
      default: begin
        unk_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      unk_r <= unk_nxt;
      va_r  <= r_pl.a[INDEX_BITS-1:0];
      vb_r  <= b_sel[INDEX_BITS-1:0];
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.vertex_a = unk_r ? '1 : OUT_W'(va_r);
  assign out_ch.vertex_b = unk_r ? '1 : OUT_W'(vb_r);

`ifndef SYNTHESIS
  a_points_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && cfg.draw_mode == MODE_POINTS |-> out_ch.vertex_a == out_ch.vertex_b)
    else $error("points result with differing endpoints");

  a_lines_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && cfg.draw_mode == MODE_LINES
    |-> $unsigned(out_ch.vertex_b) ==
        ((OUT_W'($unsigned(out_ch.vertex_a)) + OUT_W'(1)) & IDX_MASK))
    else $error("lines result not an adjacent pair");

  a_loop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (cfg.draw_mode == MODE_LINE_LOOP || cfg.draw_mode == MODE_POLYGON)
    && cfg.vertex_count != '0
    |-> $unsigned(out_ch.vertex_b) < OUT_W'(cfg.vertex_count))
    else $error("loop endpoint beyond vertex count");
`endif

endmodule

`default_nettype wire
